/* rtl/hamming_stream_encoder_macros.svh */
// Assertion macros for the hamming stream encoder RTL, used by hse_fifo.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef HAMMING_STREAM_ENCODER_MACROS_SVH
`define HAMMING_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hse_pkg.sv */
// Package for the hamming stream encoder: payload types, queue sizing and
// the code length / encoding helper functions. No dependencies.
package hse_pkg;

  localparam int MAX_CODE_LENGTH = 63;
  localparam int PAR_BITS        = 6;
  localparam int DATA_MAX        = MAX_CODE_LENGTH - PAR_BITS;  // 57
  localparam int LEN_W           = 6;

  localparam logic [LEN_W-1:0] CODE_LEN_RESET = 6'd7;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic message_bit;
    logic end_of_message;
  } hse_in_t;

  typedef struct packed {
    logic [MAX_CODE_LENGTH-1:0] codeword;
    logic [LEN_W-1:0]           source_bits;
    logic                       length_error;
  } hse_out_t;

  // One block handed from front to back
  typedef struct packed {
    logic [DATA_MAX-1:0] data;
    logic [LEN_W-1:0]    count;
    logic                err;
  } hse_blk_t;

  // Zero or a power of two cannot carry a shortened Hamming code
  function automatic logic hse_len_bad(logic [LEN_W-1:0] n);
    return (n & (n - 6'd1)) == '0;
  endfunction

  // Data bits per block: n minus the count of powers of two up to n
  function automatic logic [LEN_W-1:0] hse_data_len(logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] pw;
    pw = '0;
    for (int p = 0; p < PAR_BITS; p++) begin
      if ((7'd1 << p) <= {1'b0, n}) pw = pw + 6'd1;
    end
    return n - pw;
  endfunction

  // Positional Hamming encode. Data bits fill non-power-of-two positions in
  // order; parity 2^p is the XOR of data positions with bit p set. Bits past
  // the block length are zero, so no masking by n is needed.
  function automatic logic [MAX_CODE_LENGTH-1:0] hse_encode(logic [DATA_MAX-1:0] data);
    logic [MAX_CODE_LENGTH-1:0] cw;
    logic [PAR_BITS-1:0]        acc;
    int                         d;
    cw  = '0;
    acc = '0;
    d   = 0;
    for (int pos = 1; pos <= MAX_CODE_LENGTH; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (data[d]) begin
          cw[pos-1] = 1'b1;
          acc       = acc ^ PAR_BITS'(pos);
        end
        d++;
      end
    end
    for (int p = 0; p < PAR_BITS; p++) begin
      if (acc[p]) cw[(1 << p) - 1] = 1'b1;
    end
    return cw;
  endfunction

endpackage

/* rtl/hse_front.sv */
// Front end: holds the code length setting, gathers message bits into a
// block and pushes finished blocks (or error marks) to the queue. Uses hse_pkg.
module hse_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_en,
  input  logic [hse_pkg::LEN_W-1:0] cfg_write_data,
  input  logic                    msg_valid,
  output logic                    msg_ready,
  input  hse_pkg::hse_in_t        msg,
  output logic                    q_push,
  output hse_pkg::hse_blk_t       q_entry,
  input  logic                    q_full
);
  import hse_pkg::*;

  logic [DATA_MAX-1:0] pending_data;
  logic [LEN_W-1:0]    pending_count;
  logic [LEN_W-1:0]    data_len;
  logic                len_bad;

  logic                accept;
  logic                fire;
  logic [DATA_MAX-1:0] data_next;
  logic [LEN_W-1:0]    count_next;

  assign msg_ready = !q_full;
  assign accept    = msg_valid && msg_ready;

  // Next block contents and flush decision
  always_comb begin
    data_next  = pending_data;
    for (int i = 0; i < DATA_MAX; i++) begin
      if (pending_count == LEN_W'(i)) data_next[i] = pending_data[i] | msg.message_bit;
    end
    count_next = pending_count + 6'd1;
    fire       = (count_next >= data_len) || msg.end_of_message;
    q_push     = accept && (len_bad || fire);
    if (len_bad) begin
      q_entry = '{data: '0, count: '0, err: 1'b1};
    end else begin
      q_entry = '{data: data_next, count: count_next, err: 1'b0};
    end
  end

  // Setting and block accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      data_len      <= hse_data_len(CODE_LEN_RESET);
      len_bad       <= hse_len_bad(CODE_LEN_RESET);
      pending_data  <= '0;
      pending_count <= '0;
    end else if (cfg_write_en) begin
      data_len      <= hse_data_len(cfg_write_data);
      len_bad       <= hse_len_bad(cfg_write_data);
      pending_data  <= '0;
      pending_count <= '0;
    end else if (accept && !len_bad) begin
      if (fire) begin
        pending_data  <= '0;
        pending_count <= '0;
      end else begin
        pending_data  <= data_next;
        pending_count <= count_next;
      end
    end
  end

endmodule

/* rtl/hse_fifo.sv */
// Short block queue between the front and back ends.
// Uses hse_pkg and hamming_stream_encoder_macros.svh.
`include "hamming_stream_encoder_macros.svh"

module hse_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hse_pkg::hse_blk_t wr_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output hse_pkg::hse_blk_t rd_entry
);
  import hse_pkg::*;

  hse_blk_t           mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = count == Q_CNT_W'(Q_DEPTH);
  assign not_empty = count != '0;
  assign rd_entry  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_entry;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + Q_CNT_W'(1);
      else if (pop && !push) count <= count - Q_CNT_W'(1);
    end
  end

  `HSE_ASSERT_IMP(a_no_overflow, push, !full, "block pushed into full queue")
  `HSE_ASSERT_IMP(a_no_underflow, pop, not_empty, "block popped from empty queue")
  `HSE_ASSERT_NXT(a_push_lands, push && !pop, not_empty, "pushed block not visible")

endmodule

/* rtl/hse_back.sv */
// Back end: encodes the queued block into a codeword and holds it in the
// output register until taken. Uses hse_pkg.
module hse_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  hse_pkg::hse_blk_t q_entry,
  output logic              q_pop,
  output logic              cw_valid,
  input  logic              cw_ready,
  output hse_pkg::hse_out_t cw
);
  import hse_pkg::*;

  assign q_pop = q_not_empty && (!cw_valid || cw_ready);

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cw_valid <= 1'b0;
    end else if (q_pop) begin
      cw_valid <= 1'b1;
    end else if (cw_ready) begin
      cw_valid <= 1'b0;
    end
  end

  // Encode into the output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cw.codeword     <= hse_encode(q_entry.data);
      cw.source_bits  <= q_entry.count;
      cw.length_error <= q_entry.err;
    end
  end

endmodule

/* rtl/hamming_stream_encoder.sv */
// Top level of the serial shortened Hamming encoder: front, queue, back.
// Uses hse_pkg, hse_front, hse_fifo, hse_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  msg     | in  | msg_valid/ready    | message_bit, end_of_message
//  cw      | out | cw_valid/ready     | codeword, source_bits, length_error
//  cfg     | in  | cfg_write_en       | cfg_write_data = code_length
//
// One message bit accepted per cycle while the queue has room; a block is
// written to the queue at the edge that accepts its last bit, and is encoded
// into the output register once that register is empty or being taken.
// The encode is a combinational XOR network in front of the back end's output register.
// Reset sets code_length to 7 and empties the block and queue.
// msg_ready drops only while the two-entry queue is full, i.e. when the
// output is stalled; a cfg write clears any partial block.
module hamming_stream_encoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [hse_pkg::LEN_W-1:0] cfg_write_data,
  input  logic                      msg_valid,
  output logic                      msg_ready,
  input  hse_pkg::hse_in_t          msg,
  output logic                      cw_valid,
  input  logic                      cw_ready,
  output hse_pkg::hse_out_t         cw
);
  import hse_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_not_empty;
  hse_blk_t q_wr;
  hse_blk_t q_rd;

  hse_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .msg            (msg),
    .q_push         (q_push),
    .q_entry        (q_wr),
    .q_full         (q_full)
  );

  hse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (q_wr),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_entry  (q_rd)
  );

  hse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_entry     (q_rd),
    .q_pop       (q_pop),
    .cw_valid    (cw_valid),
    .cw_ready    (cw_ready),
    .cw          (cw)
  );

endmodule

/* sim/tb_hamming_stream_encoder.sv */
// Self-checking testbench for hamming_stream_encoder: random and directed message bits,
// code length changes between phases, codewords checked against an in-bench encoder.
// Depends on rtl/hse_pkg.sv and the encoder RTL.
module tb_hamming_stream_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hse_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_REQS  = 650;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write_en = 1'b0;
  logic [LEN_W-1:0] cfg_write_data = CODE_LEN_RESET;
  logic             msg_valid = 1'b0;
  logic             msg_ready;
  hse_in_t          msg = '0;
  logic             cw_valid;
  logic             cw_ready = 1'b0;
  hse_out_t         cw;

  hamming_stream_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .msg            (msg),
    .cw_valid       (cw_valid),
    .cw_ready       (cw_ready),
    .cw             (cw)
  );

  always #5 clk = ~clk;

  // Encoder state mirrored in the bench
  logic [LEN_W-1:0]    code_len = CODE_LEN_RESET;
  logic [DATA_MAX-1:0] blk_data = '0;
  logic [LEN_W-1:0]    blk_cnt = '0;

  hse_in_t  req_backlog[$];
  hse_out_t expected_words[$];
  hse_out_t want_word;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit req_taken = 1'b0;
  bit res_taken = 1'b0;
  int tx_gap = 0;
  int rx_stall = 0;
  int errors = 0;

  // Zero or a power of two cannot hold a shortened code
  function automatic bit length_invalid(logic [LEN_W-1:0] n);
    return (n & (n - 6'd1)) == 6'd0;
  endfunction

  // Message bits per block: n less the parity positions up to n
  function automatic int block_bits(logic [LEN_W-1:0] n);
    int pw;
    pw = 0;
    for (int p = 0; p < LEN_W; p++) begin
      if ((1 << p) <= n) pw++;
    end
    return int'(n) - pw;
  endfunction

  function automatic logic [MAX_CODE_LENGTH-1:0] hamming_word(logic [DATA_MAX-1:0] data,
                                                             logic [LEN_W-1:0] n);
    logic [MAX_CODE_LENGTH-1:0] w;
    logic [LEN_W-1:0]           syn;
    int                         d;
    w   = '0;
    syn = '0;
    d   = 0;
    // data fills the non power-of-two positions in order
    for (int pos = 1; pos <= n; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (d < DATA_MAX && data[d]) begin
          w[pos-1] = 1'b1;
          syn      = syn ^ LEN_W'(pos);
        end
        d++;
      end
    end
    // parity at 2^p covers positions with bit p set
    for (int p = 0; p < LEN_W; p++) begin
      if ((1 << p) <= n && syn[p]) w[(1 << p) - 1] = 1'b1;
    end
    return w;
  endfunction

  // Advance the mirrored state by one accepted request
  function automatic void predict_codeword(hse_in_t req);
    hse_out_t word;
    word = '0;
    if (length_invalid(code_len)) begin
      word.length_error = 1'b1;
      expected_words.push_back(word);
      return;
    end
    if (blk_cnt < DATA_MAX && req.message_bit) blk_data[blk_cnt] = 1'b1;
    blk_cnt = blk_cnt + 6'd1;
    if (int'(blk_cnt) >= block_bits(code_len) || req.end_of_message) begin
      word.codeword    = hamming_word(blk_data, code_len);
      word.source_bits = blk_cnt;
      expected_words.push_back(word);
      blk_data = '0;
      blk_cnt  = '0;
    end
  endfunction

  // Request side: note acceptance and predict
  always @(posedge clk) begin
    req_taken = !rst && msg_valid && msg_ready;
    if (req_taken) predict_codeword(msg);
  end

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (msg_valid && !req_taken) begin
      // hold the request until taken
    end else if (tx_gap > 0) begin
      msg_valid <= 1'b0;
      tx_gap--;
    end else if (req_backlog.size() > 0) begin
      msg       <= req_backlog.pop_front();
      msg_valid <= 1'b1;
      tx_gap = tx_idle_on ? $urandom_range(0, 13) : 0;
    end else begin
      msg_valid <= 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    res_taken = !rst && cw_valid && cw_ready;
    if (res_taken) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, cw);
        errors++;
      end else begin
        want_word = expected_words.pop_front();
        if (cw.codeword !== want_word.codeword) begin
          $display("%0t: codeword mismatch: expected %h, actual %h",
                   $time, want_word.codeword, cw.codeword);
          errors++;
        end
        if (cw.source_bits !== want_word.source_bits) begin
          $display("%0t: source_bits mismatch: expected %0d, actual %0d",
                   $time, want_word.source_bits, cw.source_bits);
          errors++;
        end
        if (cw.length_error !== want_word.length_error) begin
          $display("%0t: length_error mismatch: expected %b, actual %b",
                   $time, want_word.length_error, cw.length_error);
          errors++;
        end
      end
    end
  end

  // Result ready with random stalls
  always @(negedge clk) begin
    if (res_taken) rx_stall = rx_idle_on ? $urandom_range(0, 13) : 0;
    if (rx_stall > 0) begin
      cw_ready <= 1'b0;
      rx_stall--;
    end else begin
      cw_ready <= 1'b1;
    end
  end

  task automatic queue_bit(bit b, bit eom);
    hse_in_t req;
    req.message_bit    = b;
    req.end_of_message = eom;
    req_backlog.push_back(req);
  endtask

  // Hold off until every request is taken and every result has come back
  task automatic drain();
    while (req_backlog.size() > 0 || msg_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; also drops any partial block
  task automatic write_code_length(logic [LEN_W-1:0] n);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= n;
    @(posedge clk);
    code_len = n;
    blk_data = '0;
    blk_cnt  = '0;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    int               sent;
    int               budget;
    int               k;
    int               mlen;
    int               phase;
    bit               broken;
    logic [LEN_W-1:0] n;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: default length 7 (four data bits per block)
    repeat (4) queue_bit(1'b1, 1'b0);
    repeat (4) queue_bit(1'b0, 1'b0);
    queue_bit(1'b1, 1'b1);
    queue_bit(1'b0, 1'b0);
    queue_bit(1'b1, 1'b0);
    queue_bit(1'b0, 1'b1);
    queue_bit(1'b1, 1'b0);
    queue_bit(1'b0, 1'b0);
    queue_bit(1'b1, 1'b0);
    queue_bit(1'b1, 1'b1);
    // partial block left to be dropped by the write
    queue_bit(1'b1, 1'b0);
    queue_bit(1'b1, 1'b0);
    drain();

    // Shortest code: one data bit per block
    write_code_length(6'd3);
    queue_bit(1'b1, 1'b0);
    queue_bit(1'b0, 1'b1);
    drain();

    // Power-of-two length: every request flagged
    write_code_length(6'd8);
    queue_bit(1'b1, 1'b1);
    queue_bit(1'b0, 1'b0);
    drain();

    // Longest code, short flushed block
    write_code_length(6'd63);
    queue_bit(1'b1, 1'b0);
    queue_bit(1'b1, 1'b0);
    queue_bit(1'b0, 1'b1);
    drain();

    // Random phases, each with its own code length
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQS) begin
      case (phase)
        0: n = 6'd63;
        1: n = 6'd3;
        2: n = 6'd32;
        3: n = 6'd0;
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
              0: n = 6'd1;
              1: n = 6'd2;
              2: n = 6'd4;
              3: n = 6'd16;
              default: n = 6'd0;
            endcase
          end else begin
            n = LEN_W'($urandom_range(3, 63));
          end
        end
      endcase
      phase++;
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      write_code_length(n);

      if (length_invalid(n)) begin
        budget = $urandom_range(4, 12);
        repeat (budget) queue_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent += budget;
      end else begin
        k      = block_bits(n);
        budget = $urandom_range(30, 70);
        while (budget > 0) begin
          // mostly whole messages; a few with stray end marks
          broken = ($urandom_range(0, 7) == 0);
          mlen   = ($urandom_range(0, 3) == 0) ? k : $urandom_range(1, 2 * k + 2);
          for (int i = 0; i < mlen; i++) begin
            if (broken)
              queue_bit(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
            else
              queue_bit(1'($urandom_range(0, 1)), i == mlen - 1);
          end
          budget -= mlen;
          sent   += mlen;
          if ($urandom_range(0, 9) == 0) drain();
        end
      end
      drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

/* hamming_stream_encoder.f */
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_front.sv
rtl/hse_fifo.sv
rtl/hse_back.sv
rtl/hamming_stream_encoder.sv
sim/tb_hamming_stream_encoder.sv
